>>> rtl/tid_pkg.sv
`default_nettype none

package tid_pkg;

   localparam int NUM_KW     = 6;
   localparam int KW_SLOTS   = 8;
   localparam int CHAR_BITS  = 8;
   localparam int FIELD_BITS = 31;

   typedef enum logic [2:0] {
      OP_NOOP    = 3'd0,
      OP_IO      = 3'd1,
      OP_READ    = 3'd2,
      OP_WRITE   = 3'd3,
      OP_COPY    = 3'd4,
      OP_EXIT    = 3'd5,
      OP_INVALID = 3'd6
   } op_type;

   // keyword spelling, one row per keyword opcode (NOOP to EXIT), zero padded
   localparam logic [CHAR_BITS-1:0] KW_TEXT [NUM_KW][KW_SLOTS] = '{
      '{"N", "O", "_", "O", "P", 8'h00, 8'h00, 8'h00},
      '{"I", "/", "O", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"R", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"W", "R", "I", "T", "E", 8'h00, 8'h00, 8'h00},
      '{"C", "O", "P", "Y", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"E", "X", "I", "T", 8'h00, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd5, 3'd3, 3'd4, 3'd5, 3'd4, 3'd4};
   localparam logic [2:0] KW_LEN_MAX = 3'd7;

   localparam logic [CHAR_BITS-1:0] CH_SPACE      = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_ZERO       = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_NINE       = 8'h39;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_A    = 8'h41;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_Z    = 8'h5A;
   localparam logic [CHAR_BITS-1:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [CHAR_BITS-1:0] CH_SLASH      = 8'h2F;

   typedef struct packed {
      logic [CHAR_BITS-1:0] code;
      logic [3:0]           digit_val;
      logic                 is_kw;
      logic                 is_digit;
      logic                 is_space;
      logic                 last;
   } char_class_type;

   typedef struct packed {
      logic           valid;
      char_class_type data;
   } queue_xfer_type;

endpackage

`default_nettype wire

>>> rtl/tid_if.sv
`default_nettype none

interface tid_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       line_end;

   modport source (output valid, output char_code, output line_end, input ready);
   modport sink (input valid, input char_code, input line_end, output ready);
endinterface

interface tid_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [30:0] block_time;
   logic [30:0] source_address;
   logic [30:0] destination_address;
   logic        param_missing;

   modport source (output valid, output operation, output block_time,
                   output source_address, output destination_address,
                   output param_missing, input ready);
   modport sink (input valid, input operation, input block_time,
                 input source_address, input destination_address,
                 input param_missing, output ready);
endinterface

`default_nettype wire

>>> rtl/text_instruction_decoder.sv
// Text instruction decoder: one character request per cycle when ready, one response per line.
// A line's response is loaded into the output register once its last character has
// passed the queue write and then the parse step.
// Throughput: one character per cycle when the queue is not full, set by the combinational
// digit accumulator (times ten, add, saturate compare) in the back end.
// Reset (synchronous): clears parse state, queue pointers and the response valid.
`default_nettype none

module text_instruction_decoder #(
   parameter int VALUE_BITS = 31
) (
   input  wire logic clock,
   input  wire logic reset,
   tid_req_if.sink   req_bus,
   tid_rsp_if.source rsp_bus
);

   // front -> queue and queue -> back transfers
   tid_pkg::queue_xfer_type push;
   tid_pkg::queue_xfer_type pop;
   logic                    q_full;
   logic                    back_ready;

   // front: takes character requests and classifies them
   // (keyword char, digit and its value, space, line end)
   tid_front u_front (
      .req_bus (req_bus),
      .q_full  (q_full),
      .push    (push)
   );

   // two-entry queue lets the front keep accepting while the
   // response register waits on the sink
   tid_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (q_full),
      .pop       (pop),
      .pop_ready (back_ready)
   );

   // back: keyword match, operand scan, saturating accumulate,
   // and the response register
   tid_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (pop),
      .item_ready (back_ready),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire

>>> rtl/tid_front.sv
`default_nettype none

module tid_front (
   tid_req_if.sink                  req_bus,
   input  wire logic                q_full,
   output tid_pkg::queue_xfer_type  push
);

   logic [tid_pkg::CHAR_BITS-1:0] code;
   logic                          is_upper;
   logic                          is_digit;

   assign code     = req_bus.char_code;
   assign is_upper = (code >= tid_pkg::CH_UPPER_A) && (code <= tid_pkg::CH_UPPER_Z);
   assign is_digit = (code >= tid_pkg::CH_ZERO) && (code <= tid_pkg::CH_NINE);

   assign req_bus.ready = !q_full;

   always_comb begin
      push.valid          = req_bus.valid && !q_full;
      push.data.code      = code;
      push.data.is_kw     = is_upper || (code == tid_pkg::CH_UNDERSCORE)
                            || (code == tid_pkg::CH_SLASH);
      push.data.is_digit  = is_digit;
      push.data.is_space  = (code == tid_pkg::CH_SPACE);
      push.data.digit_val = is_digit ? 4'(code - tid_pkg::CH_ZERO) : 4'd0;
      push.data.last      = req_bus.line_end;
   end

endmodule

`default_nettype wire

>>> rtl/tid_queue.sv
`default_nettype none

module tid_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire tid_pkg::queue_xfer_type push,
   output logic                         full,
   output tid_pkg::queue_xfer_type      pop,
   input  wire logic                    pop_ready
);

   localparam int DEPTH = 2;

   tid_pkg::char_class_type entry_ff [DEPTH];
   logic                    wr_ptr_ff, wr_ptr_in;
   logic                    rd_ptr_ff, rd_ptr_in;
   logic [1:0]              count_ff, count_in;
   logic                    do_push, do_pop;

   assign full      = (count_ff == 2'(DEPTH));
   assign pop.valid = (count_ff != 2'd0);
   assign pop.data  = entry_ff[rd_ptr_ff];

   assign do_push = push.valid && !full;
   assign do_pop  = pop.valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/tid_back.sv
`default_nettype none

module tid_back #(
   parameter int VALUE_BITS = 31
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire tid_pkg::queue_xfer_type item,
   output logic                         item_ready,
   tid_rsp_if.source                    rsp_bus
);

   localparam int FB = tid_pkg::FIELD_BITS;
   localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

   typedef enum logic [2:0] {
      PH_SEEK, PH_SKIP1, PH_DIG1, PH_SKIP2, PH_DIG2, PH_DONE
   } phase_type;

   phase_type                          phase_ff, phase_in;
   logic [tid_pkg::NUM_KW-1:0]         match_ff, match_in;
   logic [2:0]                         len_ff, len_in;
   logic                               closed_ff, closed_in;
   logic [VALUE_BITS-1:0]              first_ff, first_in;
   logic [VALUE_BITS-1:0]              second_ff, second_in;
   logic                               first_seen_ff, first_seen_in;
   logic                               second_seen_ff, second_seen_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   tid_pkg::op_type                    rsp_op_ff, rsp_op_in;
   logic [FB-1:0]                      rsp_bt_ff, rsp_bt_in;
   logic [FB-1:0]                      rsp_sa_ff, rsp_sa_in;
   logic [FB-1:0]                      rsp_da_ff, rsp_da_in;
   logic                               rsp_miss_ff, rsp_miss_in;

   logic                               take;
   tid_pkg::char_class_type            ch;
   logic [VALUE_BITS-1:0]              sat_limit [16];
   logic [VALUE_BITS-1:0]              acc_src, acc_sum, acc_out;
   tid_pkg::op_type                    op_sel;
   logic [FB+VALUE_BITS-1:0]           first_ext, second_ext;

   // saturation thresholds, one per digit value
   for (genvar g = 0; g < 16; g++) begin : g_lim
      localparam logic [VALUE_BITS-1:0] LIM =
         VALUE_BITS'((VALUE_MAX - VALUE_BITS'(g)) / 10);
      assign sat_limit[g] = LIM;
   end

   assign ch         = item.data;
   assign item_ready = !rsp_valid_ff || rsp_bus.ready;
   assign take       = item.valid && item_ready;

   // shared accumulator: second value while in its phases, else first
   assign acc_src = ((phase_ff == PH_SKIP2) || (phase_ff == PH_DIG2)) ? second_ff : first_ff;
   assign acc_sum = (acc_src << 3) + (acc_src << 1) + VALUE_BITS'(ch.digit_val);
   assign acc_out = (acc_src > sat_limit[ch.digit_val]) ? VALUE_MAX : acc_sum;

   always_comb begin
      phase_in       = phase_ff;
      match_in       = match_ff;
      len_in         = len_ff;
      closed_in      = closed_ff;
      first_in       = first_ff;
      second_in      = second_ff;
      first_seen_in  = first_seen_ff;
      second_seen_in = second_seen_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_op_in      = rsp_op_ff;
      rsp_bt_in      = rsp_bt_ff;
      rsp_sa_in      = rsp_sa_ff;
      rsp_da_in      = rsp_da_ff;
      rsp_miss_in    = rsp_miss_ff;
      op_sel         = tid_pkg::OP_INVALID;
      first_ext      = '0;
      second_ext     = '0;

      if (take) begin
         // keyword run
         if (!closed_ff) begin
            if (ch.is_kw) begin
               for (int k = 0; k < tid_pkg::NUM_KW; k++) begin
                  if ((len_ff >= tid_pkg::KW_LEN[k])
                      || (tid_pkg::KW_TEXT[k][len_ff] != ch.code)) begin
                     match_in[k] = 1'b0;
                  end
               end
               if (len_ff != tid_pkg::KW_LEN_MAX) begin
                  len_in = len_ff + 3'd1;
               end
            end else begin
               closed_in = 1'b1;
            end
         end

         // operand scan
         case (phase_ff)
            PH_SEEK: begin
               if (ch.is_space) phase_in = PH_SKIP1;
            end
            PH_SKIP1: begin
               if (ch.is_digit) begin
                  first_in      = acc_out;
                  first_seen_in = 1'b1;
                  phase_in      = PH_DIG1;
               end else if (!ch.is_space) begin
                  phase_in = PH_DONE;
               end
            end
            PH_DIG1: begin
               if (ch.is_digit) first_in = acc_out;
               else phase_in = ch.is_space ? PH_SKIP2 : PH_DONE;
            end
            PH_SKIP2: begin
               if (ch.is_digit) begin
                  second_in      = acc_out;
                  second_seen_in = 1'b1;
                  phase_in       = PH_DIG2;
               end else if (!ch.is_space) begin
                  phase_in = PH_DONE;
               end
            end
            PH_DIG2: begin
               if (ch.is_digit) second_in = acc_out;
               else phase_in = PH_DONE;
            end
            default: begin
            end
         endcase

         if (ch.last) begin
            if (len_in != 3'd0) begin
               for (int k = tid_pkg::NUM_KW - 1; k >= 0; k--) begin
                  if (match_in[k] && (tid_pkg::KW_LEN[k] == len_in)) begin
                     op_sel = tid_pkg::op_type'(k);
                  end
               end
            end
            first_ext    = {{FB{1'b0}}, first_in};
            second_ext   = {{FB{1'b0}}, second_in};
            rsp_valid_in = 1'b1;
            rsp_op_in    = op_sel;
            rsp_bt_in    = '0;
            rsp_sa_in    = '0;
            rsp_da_in    = '0;
            rsp_miss_in  = 1'b0;
            case (op_sel)
               tid_pkg::OP_IO: begin
                  rsp_bt_in   = first_ext[FB-1:0];
                  rsp_miss_in = !first_seen_in;
               end
               tid_pkg::OP_READ: begin
                  rsp_sa_in   = first_ext[FB-1:0];
                  rsp_miss_in = !first_seen_in;
               end
               tid_pkg::OP_WRITE: begin
                  rsp_da_in   = first_ext[FB-1:0];
                  rsp_miss_in = !first_seen_in;
               end
               tid_pkg::OP_COPY: begin
                  rsp_da_in   = first_ext[FB-1:0];
                  rsp_sa_in   = second_ext[FB-1:0];
                  rsp_miss_in = !(first_seen_in && second_seen_in);
               end
               default: begin
               end
            endcase
            // line done: back to the start-of-line state
            phase_in       = PH_SEEK;
            match_in       = '1;
            len_in         = 3'd0;
            closed_in      = 1'b0;
            first_in       = '0;
            second_in      = '0;
            first_seen_in  = 1'b0;
            second_seen_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_op_ff   <= rsp_op_in;
      rsp_bt_ff   <= rsp_bt_in;
      rsp_sa_ff   <= rsp_sa_in;
      rsp_da_ff   <= rsp_da_in;
      rsp_miss_ff <= rsp_miss_in;
      if (reset) begin
         phase_ff       <= PH_SEEK;
         match_ff       <= '1;
         len_ff         <= 3'd0;
         closed_ff      <= 1'b0;
         first_ff       <= '0;
         second_ff      <= '0;
         first_seen_ff  <= 1'b0;
         second_seen_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         match_ff       <= match_in;
         len_ff         <= len_in;
         closed_ff      <= closed_in;
         first_ff       <= first_in;
         second_ff      <= second_in;
         first_seen_ff  <= first_seen_in;
         second_seen_ff <= second_seen_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid               = rsp_valid_ff;
   assign rsp_bus.operation           = rsp_op_ff;
   assign rsp_bus.block_time          = rsp_bt_ff;
   assign rsp_bus.source_address      = rsp_sa_ff;
   assign rsp_bus.destination_address = rsp_da_ff;
   assign rsp_bus.param_missing       = rsp_miss_ff;

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      take && ch.last |=> rsp_valid_ff)
      else $error("line end taken but no response loaded");

   a_last_clears_state: assert property (@(posedge clock) disable iff (reset)
      take && ch.last |=> (phase_ff == PH_SEEK) && !closed_ff && (len_ff == 3'd0)
                          && !first_seen_ff && !second_seen_ff)
      else $error("parse state not cleared after line end");

   a_miss_needs_operand_op: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_miss_ff |-> (rsp_op_ff == tid_pkg::OP_IO)
         || (rsp_op_ff == tid_pkg::OP_READ) || (rsp_op_ff == tid_pkg::OP_WRITE)
         || (rsp_op_ff == tid_pkg::OP_COPY))
      else $error("missing parameter flagged on an operation without operands");

   a_no_operand_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ((rsp_op_ff == tid_pkg::OP_NOOP) || (rsp_op_ff == tid_pkg::OP_EXIT)
         || (rsp_op_ff == tid_pkg::OP_INVALID))
      |-> (rsp_bt_ff == '0) && (rsp_sa_ff == '0) && (rsp_da_ff == '0))
      else $error("operand fields nonzero for an operation without operands");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |=> rsp_valid_ff)
      else $error("pending response dropped");

endmodule

`default_nettype wire
